[rtl/lsc_pkg.sv]
// shared types and constants of the line sensor centroid block
package lsc_pkg;

   // frame geometry and sample width
   localparam int SENSOR_COUNT     = 14;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int INDEX_BITS       = 4;
   localparam int WEIGHT_BITS      = 6;

   // centroid divider widths: dividend is 2*|sum|*32768 + 7*count, divisor 14*count
   localparam int DIVIDEND_BITS    = 22;
   localparam int DIVISOR_BITS     = 8;

   // configuration register indexes
   localparam logic [1:0] CSR_FULL_SCALE    = 2'd0;
   localparam logic [1:0] CSR_HIT_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_LOST_NUDGE    = 2'd2;

   // configuration reset values
   localparam logic [15:0] FULL_SCALE_RST    = 16'hFFFF;
   localparam logic [15:0] HIT_THRESHOLD_RST = 16'h8000;
   localparam logic [15:0] LOST_NUDGE_RST    = 16'h0000;

   // position weight of each sensor, symmetric around the center
   localparam logic signed [4:0] POS_WEIGHT [SENSOR_COUNT] = '{
      -5'sd7, -5'sd6, -5'sd5, -5'sd4, -5'sd3, -5'sd2, -5'sd1,
       5'sd1,  5'sd2,  5'sd3,  5'sd4,  5'sd5,  5'sd6,  5'sd7
   };

   // running frame totals from the accumulator
   typedef struct packed {
      logic [SENSOR_COUNT-1:0] mask;
      logic [3:0]              count;
      logic [WEIGHT_BITS-1:0]  weight_sum;
      logic                    last;
   } frame_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[rtl/lsc_frame_acc.sv]
// per-sample inversion, threshold compare and frame accumulation
module lsc_frame_acc #(
   parameter int SAMPLE_BITS = lsc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat,
   input  logic                clear,
   input  logic [15:0]         sample,
   input  logic [15:0]         full_scale,
   input  logic [15:0]         hit_threshold,
   output lsc_pkg::frame_type  frame
);

   logic [lsc_pkg::INDEX_BITS-1:0]   idx_ff, idx_in;
   logic [lsc_pkg::SENSOR_COUNT-1:0] mask_ff, mask_in;
   logic [3:0]                       count_ff, count_in;
   logic [lsc_pkg::WEIGHT_BITS-1:0]  wsum_ff, wsum_in;
   logic [SAMPLE_BITS-1:0]           inv;
   logic                             hit;
   logic                             last;

   // inversion wraps at the sample width
   assign inv  = full_scale[SAMPLE_BITS-1:0] - sample[SAMPLE_BITS-1:0];
   assign hit  = 16'(inv) > hit_threshold;
   assign last = idx_ff == lsc_pkg::INDEX_BITS'(lsc_pkg::SENSOR_COUNT - 1);

   // next totals
   always_comb begin
      idx_in   = idx_ff;
      mask_in  = mask_ff;
      count_in = count_ff;
      wsum_in  = wsum_ff;
      if (clear) begin
         idx_in   = '0;
         mask_in  = '0;
         count_in = '0;
         wsum_in  = '0;
      end else if (beat) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
         if (hit) begin
            mask_in[idx_ff] = 1'b1;
            count_in        = count_ff + 1'b1;
            wsum_in         = wsum_ff
                              + lsc_pkg::WEIGHT_BITS'(lsc_pkg::POS_WEIGHT[idx_ff]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         mask_ff  <= '0;
         count_ff <= '0;
         wsum_ff  <= '0;
      end else begin
         idx_ff   <= idx_in;
         mask_ff  <= mask_in;
         count_ff <= count_in;
         wsum_ff  <= wsum_in;
      end
   end

   assign frame.mask       = mask_ff;
   assign frame.count      = count_ff;
   assign frame.weight_sum = wsum_ff;
   assign frame.last       = last;

endmodule

[rtl/lsc_div.sv]
// restoring divider, one quotient bit per cycle
module lsc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [lsc_pkg::DIVIDEND_BITS-1:0]  dividend,
   input  logic [lsc_pkg::DIVISOR_BITS-1:0]   divisor,
   output logic [lsc_pkg::DIVIDEND_BITS-1:0]  quotient,
   output lsc_pkg::div_stat_type              stat
);

   localparam int CNT_BITS = $clog2(lsc_pkg::DIVIDEND_BITS);

   logic [lsc_pkg::DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [lsc_pkg::DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [lsc_pkg::DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [CNT_BITS-1:0]               cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [lsc_pkg::DIVISOR_BITS:0]    trial;
   logic [lsc_pkg::DIVISOR_BITS:0]    diff;
   logic                              ge;

   // one trial subtract per cycle
   assign trial = {rem_ff, quo_ff[lsc_pkg::DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_BITS'(lsc_pkg::DIVIDEND_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[lsc_pkg::DIVIDEND_BITS-2:0], ge};
         rem_in = ge ? diff[lsc_pkg::DIVISOR_BITS-1:0] : trial[lsc_pkg::DIVISOR_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[rtl/line_sensor_centroid_core.sv]
// top level of the line sensor centroid block
//
// Samples of one frame arrive on the req_ stream, one beat per sensor, sensor 0
// first; 14 beats make a frame. Each sample is inverted against full_scale and
// compared with hit_threshold. After the last beat of a frame one result beat
// leaves on the rsp_ stream with the centroid offset (signed Q1.15), hit mask,
// hit count and a line-lost flag in tuser. A frame with no hit moves the kept
// offset by lost_nudge, with saturation, and reports that.
// The first 13 samples are only accumulated and do not hold the stream. After
// the last sample the sequencer passes ST_CALC; a frame with hits then runs a
// restoring divide, one quotient bit per cycle in lsc_div, while a frame with
// no hit goes straight to ST_DONE; req_tready is low from the last beat until
// the result is loaded into the output register.
// The result sits in an output register; further samples are taken while it
// waits, but a frame that completes while it is still held back by
// rsp_tready waits before loading.
// Configuration writes on csr_ take effect the next cycle. Synchronous reset
// restores the register defaults, clears the frame and sets the offset to zero.
module line_sensor_centroid_core #(
   parameter int SAMPLE_BITS = lsc_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // sample stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] offset_q15, [29:16] hit_mask, [33:30] hit_count
   output logic        rsp_tuser,   // [0] line_lost
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [15:0]                        full_scale_ff, hit_threshold_ff, lost_nudge_ff;
   logic [15:0]                        cur_offset_ff, cur_offset_in;
   logic [15:0]                        res_offset_ff, res_offset_in;
   logic                               res_lost_ff, res_lost_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [15:0]                        rsp_offset_ff;
   logic [lsc_pkg::SENSOR_COUNT-1:0]   rsp_mask_ff;
   logic [3:0]                         rsp_count_ff;
   logic                               rsp_lost_ff;
   logic                               req_beat;
   logic                               out_free;
   logic                               load;
   logic                               div_start;
   lsc_pkg::frame_type                 frame;
   lsc_pkg::div_stat_type              div_stat;
   logic [lsc_pkg::DIVIDEND_BITS-1:0]  dividend;
   logic [lsc_pkg::DIVIDEND_BITS-1:0]  quotient;
   logic [lsc_pkg::DIVISOR_BITS-1:0]   divisor;
   logic [lsc_pkg::WEIGHT_BITS-1:0]    abs_sum;
   logic [6:0]                         den;
   logic                               q_big;
   logic [16:0]                        nudge_sum;

   assign req_tready = state_ff == ST_IDLE;
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load       = (state_ff == ST_DONE) && out_free;
   assign div_start  = (state_ff == ST_CALC) && (frame.count != '0);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff    <= lsc_pkg::FULL_SCALE_RST;
         hit_threshold_ff <= lsc_pkg::HIT_THRESHOLD_RST;
         lost_nudge_ff    <= lsc_pkg::LOST_NUDGE_RST;
      end else if (csr_we) begin
         case (csr_index)
            lsc_pkg::CSR_FULL_SCALE:    full_scale_ff    <= csr_wdata;
            lsc_pkg::CSR_HIT_THRESHOLD: hit_threshold_ff <= csr_wdata;
            lsc_pkg::CSR_LOST_NUDGE:    lost_nudge_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   lsc_frame_acc #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_acc (
      .clock         (clock),
      .reset         (reset),
      .beat          (req_beat),
      .clear         (load),
      .sample        (req_tdata),
      .full_scale    (full_scale_ff),
      .hit_threshold (hit_threshold_ff),
      .frame         (frame)
   );

   // divider operands: (2*|sum|*32768 + 7*count) / (14*count)
   assign abs_sum  = frame.weight_sum[lsc_pkg::WEIGHT_BITS-1]
                     ? lsc_pkg::WEIGHT_BITS'(6'd0 - frame.weight_sum)
                     : frame.weight_sum;
   assign den      = {frame.count, 3'b000} - {3'b000, frame.count};
   assign dividend = {1'b0, abs_sum[4:0], 16'h0000} + lsc_pkg::DIVIDEND_BITS'(den);
   assign divisor  = {den, 1'b0};

   lsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // saturation checks for the centroid and the nudged offset
   assign q_big     = |quotient[lsc_pkg::DIVIDEND_BITS-1:15];
   assign nudge_sum = {cur_offset_ff[15], cur_offset_ff} + {lost_nudge_ff[15], lost_nudge_ff};

   // sequencer
   always_comb begin
      state_in      = state_ff;
      res_offset_in = res_offset_ff;
      res_lost_in   = res_lost_ff;
      cur_offset_in = cur_offset_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat && frame.last) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (frame.count == '0) begin
               res_lost_in = 1'b1;
               if (nudge_sum[16] != nudge_sum[15]) begin
                  res_offset_in = nudge_sum[16] ? 16'h8000 : 16'h7FFF;
               end else begin
                  res_offset_in = nudge_sum[15:0];
               end
               state_in = ST_DONE;
            end else begin
               res_lost_in = 1'b0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (frame.weight_sum[lsc_pkg::WEIGHT_BITS-1]) begin
                  res_offset_in = q_big ? 16'h8000 : 16'h0000 - quotient[15:0];
               end else begin
                  res_offset_in = q_big ? 16'h7FFF : quotient[15:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cur_offset_in = res_offset_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_offset_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_offset_ff <= cur_offset_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      res_offset_ff <= res_offset_in;
      res_lost_ff   <= res_lost_in;
      if (load) begin
         rsp_offset_ff <= res_offset_ff;
         rsp_mask_ff   <= frame.mask;
         rsp_count_ff  <= frame.count;
         rsp_lost_ff   <= res_lost_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_count_ff, rsp_mask_ff, rsp_offset_ff};
   assign rsp_tuser  = rsp_lost_ff;

   // no sample is taken while the divider runs
   a_no_beat_in_div : assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !req_tready)
      else $error("sample accepted while divider busy");

   // divider finishes only while the sequencer waits for it
   a_done_in_div : assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider done outside divide state");

   // reported count matches the reported mask
   a_count_mask : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_mask_ff) == 32'(rsp_count_ff))
      else $error("hit count does not match hit mask");

   // a lost line carries no hits
   a_lost_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_count_ff == '0 && rsp_mask_ff == '0))
      else $error("line lost reported with hits");

endmodule
